@@ hw/rtl/ffsa_pkg.sv @@
// Shared types and constants for the first-fit slot allocator.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps

package ffsa_pkg;

  // Bitmap storage word: 64 busy bits, addressed by the slot index bits from bit 6 up.
  localparam int WORD_W = 64;
  localparam int BIT_W  = 6;

  // Command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_ALLOC = 2'd2
  } status_e;

  typedef struct packed {
    logic       cmd;
    logic [9:0] slot_index;
  } in_word_t;

  typedef struct packed {
    status_e    status;
    logic [9:0] granted_slot;
  } out_word_t;

  // Masking control for one scan step.
  typedef struct packed {
    logic             first;  // word holds the hint: ignore bits below lo
    logic [BIT_W-1:0] lo;
    logic             last;   // last word: ignore bits past the pool
  } scan_ctl_t;

endpackage

@@ hw/rtl/first_fit_slot_allocator_top.sv @@
// Top level of the first-fit slot allocator: sequencer, hint and result register.
// Depends on ffsa_pkg, ffsa_bitmap_mem and ffsa_scan_unit.
`timescale 1ns / 1ps
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+----------------------------------
//  in      | input     | in_valid_i/in_stall_o | in_word_i  (cmd, slot_index)
//  out     | output    | out_valid_o/out_stall_i | out_word_o (status, granted_slot)
//
//  Sequence: allocate reads the hint word (S_RD), then the scan unit checks
//    one 64-bit word per cycle from there (S_SCAN), up to SLOTS/64 words, until
//    a free bit is found or the last word is scanned; then S_RESP. A pool-full
//    hint or an out-of-pool free goes straight to S_RESP. Free goes S_RD, S_FCHK, S_RESP.
//  Reset: after rst_ni the bitmap memory is cleared one word per cycle,
//    all SLOTS/64 words (16 with the defaults); in_stall_o is high meanwhile.
//  Stalls: one item at a time; in_stall_o is low only while idle. A
//    finished result waits in the response state until the output register
//    is free, so out_stall_i never drops or repeats a word.

module first_fit_slot_allocator_top #(
  parameter int GROUP_SIZE = 256,
  parameter int GROUPS     = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ffsa_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ffsa_pkg::out_word_t out_word_o
);

  // Geometry
  localparam int SLOTS     = GROUP_SIZE * GROUPS;
  localparam int WW        = ffsa_pkg::WORD_W;
  localparam int BW        = ffsa_pkg::BIT_W;
  localparam int NWORDS    = (SLOTS + WW - 1) / WW;
  localparam int AW        = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int TAIL_BITS = SLOTS - (NWORDS - 1) * WW;
  localparam int SLOT_W    = AW + BW;                  // word-aligned slot index
  localparam int XW        = SLOT_W + 1;               // holds SLOTS itself
  localparam int HW        = $clog2(SLOTS + 1);        // search hint width
  localparam int IW        = (XW > 10) ? XW : 10;      // free index, extended
  localparam int GW        = (SLOT_W > 10) ? SLOT_W : 10;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_RD    = 6'b000100,
    S_SCAN  = 6'b001000,
    S_FCHK  = 6'b010000,
    S_RESP  = 6'b100000
  } state_e;

  state_e                state_q, state_d;
  logic [AW-1:0]         clr_q, clr_d;
  logic [HW-1:0]         hint_q, hint_d;
  logic [AW-1:0]         addr_q, addr_d;       // word being read / scanned
  logic                  first_q, first_d;
  logic                  cmd_q, cmd_d;
  logic [BW-1:0]         bit_q, bit_d;         // bit of the slot to free
  logic [IW-1:0]         idx_q, idx_d;
  ffsa_pkg::status_e     res_status_q, res_status_d;
  logic [9:0]            res_slot_q, res_slot_d;
  logic                  out_valid_q, out_valid_d;
  ffsa_pkg::out_word_t   out_word_q, out_word_d;

  // Memory port
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [WW-1:0]         mem_wdata, mem_rdata;

  // Scan unit
  ffsa_pkg::scan_ctl_t   scan_ctl;
  logic                  scan_found;
  logic [BW-1:0]         scan_pos;

  // Derived values
  logic [XW-1:0]         hint_x;
  logic [IW-1:0]         in_idx_x;
  logic [SLOT_W-1:0]     found_slot;
  logic [XW-1:0]         hint_next;
  logic [GW-1:0]         grant_x;
  logic                  last_word;
  logic                  in_fire;

  ffsa_bitmap_mem #(
    .DEPTH (NWORDS),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ffsa_scan_unit #(
    .TAIL_BITS (TAIL_BITS)
  ) u_scan (
    .busy_i  (mem_rdata),
    .ctl_i   (scan_ctl),
    .found_o (scan_found),
    .pos_o   (scan_pos)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;

  assign hint_x     = XW'(hint_q);
  assign in_idx_x   = IW'(in_word_i.slot_index);
  assign last_word  = (addr_q == AW'(NWORDS - 1));
  assign found_slot = {addr_q, scan_pos};
  assign hint_next  = {1'b0, found_slot} + XW'(1);
  assign grant_x    = GW'(found_slot);

  assign scan_ctl.first = first_q;
  assign scan_ctl.lo    = hint_x[BW-1:0];
  assign scan_ctl.last  = last_word;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    hint_d       = hint_q;
    addr_d       = addr_q;
    first_d      = first_q;
    cmd_d        = cmd_q;
    bit_d        = bit_q;
    idx_d        = idx_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_word_d   = out_word_q;
    mem_we       = 1'b0;
    mem_waddr    = addr_q;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = addr_q;

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        if (clr_q == AW'(NWORDS - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          cmd_d = in_word_i.cmd;
          idx_d = in_idx_x;
          if (in_word_i.cmd == ffsa_pkg::CMD_ALLOC) begin
            if (32'(hint_q) >= SLOTS) begin
              res_status_d = ffsa_pkg::ST_FULL;
              res_slot_d   = '0;
              state_d      = S_RESP;
            end else begin
              addr_d  = hint_x[AW+BW-1:BW];
              first_d = 1'b1;
              state_d = S_RD;
            end
          end else begin
            if (32'(in_word_i.slot_index) >= SLOTS) begin
              res_status_d = ffsa_pkg::ST_NOT_ALLOC;
              res_slot_d   = '0;
              state_d      = S_RESP;
            end else begin
              addr_d  = in_idx_x[AW+BW-1:BW];
              bit_d   = in_idx_x[BW-1:0];
              state_d = S_RD;
            end
          end
        end
      end

      S_RD: begin
        mem_re  = 1'b1;
        state_d = (cmd_q == ffsa_pkg::CMD_ALLOC) ? S_SCAN : S_FCHK;
      end

      S_SCAN: begin
        if (scan_found) begin
          mem_we       = 1'b1;
          mem_wdata    = mem_rdata | (WW'(1) << scan_pos);
          hint_d       = hint_next[HW-1:0];
          res_status_d = ffsa_pkg::ST_OK;
          res_slot_d   = grant_x[9:0];
          state_d      = S_RESP;
        end else if (last_word) begin
          res_status_d = ffsa_pkg::ST_FULL;
          res_slot_d   = '0;
          state_d      = S_RESP;
        end else begin
          // read the next word while this one is retired
          mem_re    = 1'b1;
          mem_raddr = addr_q + AW'(1);
          addr_d    = addr_q + AW'(1);
          first_d   = 1'b0;
        end
      end

      S_FCHK: begin
        res_slot_d = '0;
        if (mem_rdata[bit_q]) begin
          mem_we       = 1'b1;
          mem_wdata    = mem_rdata & ~(WW'(1) << bit_q);
          res_status_d = ffsa_pkg::ST_OK;
          if (idx_q < IW'(hint_q)) begin
            hint_d = idx_q[HW-1:0];
          end
        end else begin
          res_status_d = ffsa_pkg::ST_NOT_ALLOC;
        end
        state_d = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d             = 1'b1;
          out_word_d.status       = res_status_q;
          out_word_d.granted_slot = res_slot_q;
          state_d                 = S_IDLE;
        end
      end

      default: begin
        state_d = S_CLEAR;
        clr_d   = '0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      hint_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      hint_q      <= hint_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    addr_q       <= addr_d;
    first_q      <= first_d;
    cmd_q        <= cmd_d;
    bit_q        <= bit_d;
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    out_word_q   <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // Checks
  a_hint_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(hint_q) <= SLOTS)
    else $error("search hint beyond the pool");

  a_grant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status != ffsa_pkg::ST_OK) |-> out_word_o.granted_slot == '0)
    else $error("nonzero slot on a failed request");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_CLEAR) || (state_q == S_SCAN) || (state_q == S_FCHK))
    else $error("bitmap written outside clear, scan or free check");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_RD) || (state_q == S_RESP))
    else $error("accepted word did not start work");

  a_resp_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP) && (state_d == S_IDLE) |=> out_valid_q)
    else $error("result left without loading the output register");

endmodule

@@ hw/rtl/ffsa_bitmap_mem.sv @@
// Busy-bitmap storage: one write port, one read port with registered data.
// Depends on ffsa_pkg for the word width.
`timescale 1ns / 1ps

module ffsa_bitmap_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AW-1:0]                waddr_i,
  input  logic [ffsa_pkg::WORD_W-1:0]  wdata_i,
  input  logic                         re_i,
  input  logic [AW-1:0]                raddr_i,
  output logic [ffsa_pkg::WORD_W-1:0]  rdata_o
);

  logic [ffsa_pkg::WORD_W-1:0] mem [DEPTH];
  logic [ffsa_pkg::WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/ffsa_scan_unit.sv @@
// Scan unit: masks one bitmap word and finds its lowest free bit.
// Depends on ffsa_pkg for the word width and the scan control struct.
`timescale 1ns / 1ps

module ffsa_scan_unit #(
  parameter int TAIL_BITS = 64
) (
  input  logic [ffsa_pkg::WORD_W-1:0] busy_i,
  input  ffsa_pkg::scan_ctl_t         ctl_i,
  output logic                        found_o,
  output logic [ffsa_pkg::BIT_W-1:0]  pos_o
);

  localparam int BW = ffsa_pkg::BIT_W;

  logic [ffsa_pkg::WORD_W-1:0] free_v;

  // Candidate bits: free, at or above the hint, inside the pool.
  always_comb begin
    for (int i = 0; i < ffsa_pkg::WORD_W; i++) begin
      free_v[i] = !busy_i[i]
                  && (!ctl_i.first || (BW'(i) >= ctl_i.lo))
                  && (!ctl_i.last || (i < TAIL_BITS));
    end
  end

  // Priority encoder, lowest index wins.
  always_comb begin
    found_o = 1'b0;
    pos_o   = '0;
    for (int i = ffsa_pkg::WORD_W - 1; i >= 0; i--) begin
      if (free_v[i]) begin
        found_o = 1'b1;
        pos_o   = BW'(i);
      end
    end
  end

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for first_fit_slot_allocator_top: allocate and free words are
// checked against an in-bench bitmap and search-hint model. Depends on ffsa_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int GROUP_SIZE     = 256;
  localparam int GROUPS         = 4;
  localparam int SLOTS          = GROUP_SIZE * GROUPS;
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either side
  localparam int DRAIN_CYCLES   = 40;    // longest scan plus margin

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                out_stall_i = 1'b0;
  ffsa_pkg::in_word_t  in_word_i   = '0;
  logic                in_stall_o;
  logic                out_valid_o;
  ffsa_pkg::out_word_t out_word_o;

  first_fit_slot_allocator_top #(
    .GROUP_SIZE (GROUP_SIZE),
    .GROUPS     (GROUPS)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // Model of the pool: busy bitmap, search hint and occupancy.
  bit          pool_busy [SLOTS];
  logic [10:0] pool_hint;
  int          pool_used;

  ffsa_pkg::out_word_t pending_answers [$];
  int                  answer_errors;

  // Idle rates in percent; hold_req asks the receiver for a long hold-off.
  int                  in_idle_pct  = 8;
  int                  out_idle_pct = 8;
  int                  hold_req     = 0;
  int                  hold_left    = 0;
  int                  quiet_cycles = 0;
  ffsa_pkg::out_word_t want_word;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Expected answer for one accepted request; updates the model state.
  function automatic ffsa_pkg::out_word_t predict_slot_answer(ffsa_pkg::in_word_t req);
    ffsa_pkg::out_word_t ans;
    int                  s;
    ans.status       = ffsa_pkg::ST_NOT_ALLOC;
    ans.granted_slot = '0;
    if (req.cmd == ffsa_pkg::CMD_ALLOC) begin
      ans.status = ffsa_pkg::ST_FULL;
      for (s = int'(pool_hint); s < SLOTS; s++) begin
        if (!pool_busy[s]) begin
          pool_busy[s]     = 1'b1;
          pool_hint        = 11'(s + 1);
          pool_used++;
          ans.status       = ffsa_pkg::ST_OK;
          ans.granted_slot = 10'(s);
          return ans;
        end
      end
      return ans;
    end
    // Out-of-pool index or a slot that is already free: nothing changes.
    if (int'(req.slot_index) >= SLOTS || !pool_busy[req.slot_index])
      return ans;
    pool_busy[req.slot_index] = 1'b0;
    pool_used--;
    if ({1'b0, req.slot_index} < pool_hint)
      pool_hint = {1'b0, req.slot_index};
    ans.status = ffsa_pkg::ST_OK;
    return ans;
  endfunction

  function automatic ffsa_pkg::in_word_t make_request(logic cmd, int idx);
    ffsa_pkg::in_word_t req;
    req.cmd        = cmd;
    req.slot_index = 10'(idx);
    return req;
  endfunction

  // Random word; frees mostly aim at busy slots so that they reach the clearing path.
  function automatic ffsa_pkg::in_word_t random_request(int alloc_pct);
    ffsa_pkg::in_word_t req;
    int                 start;
    int                 k;
    req.slot_index = 10'($urandom_range(1023));
    req.cmd        = ffsa_pkg::CMD_FREE;
    if ($urandom_range(99) < alloc_pct) begin
      req.cmd = ffsa_pkg::CMD_ALLOC;
    end else if ($urandom_range(99) < 80) begin
      start = $urandom_range(SLOTS - 1);
      for (k = 0; k < SLOTS; k++) begin
        if (pool_busy[(start + k) % SLOTS]) begin
          req.slot_index = 10'((start + k) % SLOTS);
          break;
        end
      end
    end
    return req;
  endfunction

  // Offer one word, hold it until accepted, then log the expected answer.
  // Valid is only lowered for an idle cycle, never between back-to-back words.
  task automatic offer_request(input ffsa_pkg::in_word_t req);
    while (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      in_word_i  <= ffsa_pkg::in_word_t'($urandom);
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    pending_answers.push_back(predict_slot_answer(req));
  endtask

  // Frees of free slots at both ends, then allocs and frees that move the
  // hint down, leave it in place, and make the scan skip a busy slot.
  task automatic test_directed_corners();
    offer_request(make_request(ffsa_pkg::CMD_FREE, 0));
    offer_request(make_request(ffsa_pkg::CMD_FREE, 1023));
    offer_request(make_request(ffsa_pkg::CMD_ALLOC, 1023));  // index ignored on allocate
    offer_request(make_request(ffsa_pkg::CMD_ALLOC, 0));
    offer_request(make_request(ffsa_pkg::CMD_ALLOC, 512));
    offer_request(make_request(ffsa_pkg::CMD_FREE, 0));      // hint drops to 0
    offer_request(make_request(ffsa_pkg::CMD_FREE, 2));      // above the hint: hint stays
    offer_request(make_request(ffsa_pkg::CMD_FREE, 2));      // already free
    offer_request(make_request(ffsa_pkg::CMD_ALLOC, 0));
    offer_request(make_request(ffsa_pkg::CMD_ALLOC, 0));     // skips busy slot 1
    offer_request(make_request(ffsa_pkg::CMD_ALLOC, 0));
  endtask

  // Allocate until the pool is full, poke at pool full, then reuse the top
  // slot and slots spread over different bitmap words.
  task automatic test_fill_pool();
    while (pool_hint < SLOTS)
      offer_request(make_request(ffsa_pkg::CMD_ALLOC, $urandom_range(1023)));
    offer_request(make_request(ffsa_pkg::CMD_ALLOC, 0));
    offer_request(make_request(ffsa_pkg::CMD_ALLOC, 1023));
    offer_request(make_request(ffsa_pkg::CMD_FREE, 1023));
    offer_request(make_request(ffsa_pkg::CMD_ALLOC, 0));     // grants the top slot
    offer_request(make_request(ffsa_pkg::CMD_FREE, 512));
    offer_request(make_request(ffsa_pkg::CMD_FREE, 5));
    offer_request(make_request(ffsa_pkg::CMD_ALLOC, 0));
    offer_request(make_request(ffsa_pkg::CMD_ALLOC, 0));
    offer_request(make_request(ffsa_pkg::CMD_ALLOC, 0));     // full again
  endtask

  // Random mix that keeps occupancy drifting around half full.
  task automatic test_random_mix(input int count);
    int n;
    for (n = 0; n < count; n++) begin
      if (pool_used > 800)
        offer_request(random_request(25));
      else if (pool_used < 200)
        offer_request(random_request(75));
      else
        offer_request(random_request(50));
    end
  endtask

  // Receiver holds off while words keep coming, so the block backs up its input.
  task automatic test_output_hold_off();
    int n;
    hold_req = 300;
    for (n = 0; n < 20; n++)
      offer_request(random_request(50));
  endtask

  // A long stretch with no idle cycles on either side.
  task automatic test_back_to_back(input int count);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    test_random_mix(count);
    in_idle_pct  = 8;
    out_idle_pct = 8;
  endtask

  // Receiver: random stall, or a counted hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= (out_idle_pct > 0 && $urandom_range(99) < out_idle_pct);
    end
  end

  // Every accepted answer is checked against the oldest expected one.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_answers.size() == 0) begin
        answer_errors++;
        $display("%0t: unexpected answer, expected none, got status %0d slot %0d",
                 $time, out_word_o.status, out_word_o.granted_slot);
      end else begin
        want_word = pending_answers.pop_front();
        if (out_word_o.status !== want_word.status) begin
          answer_errors++;
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want_word.status, out_word_o.status);
        end
        if (out_word_o.granted_slot !== want_word.granted_slot) begin
          answer_errors++;
          $display("%0t: granted_slot mismatch, expected %0d, got %0d",
                   $time, want_word.granted_slot, out_word_o.granted_slot);
        end
      end
    end
  end

  // Watchdog: too long without a word moving on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    answer_errors = 0;
    pool_hint     = '0;
    pool_used     = 0;
    foreach (pool_busy[i]) pool_busy[i] = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_corners();
    test_fill_pool();
    test_random_mix(500);
    test_output_hold_off();
    test_back_to_back(150);
    test_random_mix(150);

    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (answer_errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
